@@ design/cbrt_pkg.sv @@
// ----------------------------------------------------------------------------
// cbrt_pkg: shared definitions for the Newton cube root unit
// Fixed-point format, derived widths, register indexes, sequencer states and
// the structs that travel between the sequencer, the divider and the top level.
// ----------------------------------------------------------------------------
package cbrt_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // The numerator a * 2^(2*FRAC_BITS) sets the divider's dividend width.
  localparam int NUM_W = DATA_WIDTH + 2 * FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);

  localparam int TOL_W   = 16;
  localparam int ITER_W  = 8;
  localparam int PDATA_W = 32;
  localparam int PADDR_W = 3;

  localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(64);
  localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(1);

  typedef enum logic {
    REG_TOLERANCE  = 1'b0,
    REG_ITER_LIMIT = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEED_MUL,
    S_SEED,
    S_DIV1,
    S_DIV2,
    S_STEP_MUL,
    S_STEP,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [TOL_W-1:0]  tolerance;
    logic [ITER_W-1:0] iteration_limit;
  } cfg_t;

  typedef struct packed {
    logic                  start;
    logic [NUM_W-1:0]      dividend;
    logic [DATA_WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] root;
    logic [ITER_W-1:0]     iterations_used;
    logic                  converged;
  } res_t;

endpackage

@@ design/cbrt_div.sv @@
// ----------------------------------------------------------------------------
// cbrt_div: shared restoring divider
// Divides an NUM_W-bit dividend by a DATA_WIDTH-bit divisor, one quotient bit
// per cycle. done pulses for one cycle when the quotient is final.
// ----------------------------------------------------------------------------
module cbrt_div
  import cbrt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  div_req_t             req,
  output logic                 done,
  output logic [NUM_W-1:0]     quotient
);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] dvs;
  logic [NUM_W-1:0]      quo;

  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;
  logic                  fits;

  assign shifted = {rem, quo[NUM_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
      cnt <= CNT_W'(NUM_W - 1);
    end else if (busy) begin
      rem <= fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      quo <= {quo[NUM_W-2:0], fits};
      cnt <= cnt - CNT_W'(1);
    end
  end

  assign quotient = quo;

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider started while busy");

endmodule

@@ design/cbrt_ctrl.sv @@
// ----------------------------------------------------------------------------
// cbrt_ctrl: Newton iteration sequencer
// Holds the radicand and the current estimate, steps the shared divider
// through the two divisions by the estimate in each Newton step, and divides
// by three with a registered reciprocal multiplication.
// ----------------------------------------------------------------------------
module cbrt_ctrl
  import cbrt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_WIDTH-1:0] radicand,
  output logic                  res_valid,
  input  logic                  res_ready,
  output res_t                  res,
  output div_req_t              div_req,
  input  logic                  div_done,
  input  logic [NUM_W-1:0]      div_quo
);

  // floor(l/3) = (l * RECIP3) >> (DATA_WIDTH+1) for every DATA_WIDTH-bit l.
  // A wider dividend is split as h*2^DATA_WIDTH + l, where
  // 2^DATA_WIDTH = 3*WRAP_THIRD + WRAP_REM.
  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam logic [DATA_WIDTH-1:0] RECIP3 =
    DATA_WIDTH'(((64'd1 << (DATA_WIDTH + 1)) + 64'd2) / 64'd3);
  localparam logic [DATA_WIDTH-1:0] WRAP_THIRD = DATA_WIDTH'((64'd1 << DATA_WIDTH) / 64'd3);
  localparam logic [2:0]            WRAP_REM   = 3'((64'd1 << DATA_WIDTH) % 64'd3);

  state_t                state, state_next;
  logic [DATA_WIDTH-1:0] a, a_next;
  logic [DATA_WIDTH-1:0] x, x_next;
  logic [ITER_W-1:0]     iters, iters_next;
  logic                  conv, conv_next;
  logic [DATA_WIDTH-1:0] third_l, third_l_next;
  logic [1:0]            third_h, third_h_next;
  logic [PROD_W-1:0]     third_prod;

  logic [DATA_WIDTH-2:0] third_lo_q;
  logic [1:0]            third_lo_r;
  logic [2:0]            third_carry_sum;
  logic [DATA_WIDTH-1:0] third_hi;
  logic [DATA_WIDTH-1:0] third_carry;
  logic [DATA_WIDTH-1:0] third_q;

  logic [DATA_WIDTH-1:0] init_x;
  logic [NUM_W-1:0]      numer;
  logic [DATA_WIDTH-1:0] quo_sat;
  logic [DATA_WIDTH+1:0] sum3;
  logic [DATA_WIDTH-1:0] nx;
  logic [DATA_WIDTH-1:0] step;
  logic                  tol_ok;
  logic [ITER_W-1:0]     iters_inc;

  // An estimate of zero is used as one when it is a divisor.
  function automatic logic [DATA_WIDTH-1:0] nonzero(input logic [DATA_WIDTH-1:0] v);
    return (v == '0) ? DATA_WIDTH'(1) : v;
  endfunction

  // Quotient of the low word, its remainder (only the low two bits matter,
  // since it is at most two), and the carry that the high part adds.
  assign third_lo_q      = third_prod[PROD_W-1:DATA_WIDTH+1];
  assign third_lo_r      = third_l[1:0] - (third_lo_q[1:0] * 2'd3);
  assign third_carry_sum = ({1'b0, third_h} * WRAP_REM) + {1'b0, third_lo_r};
  assign third_hi        = (third_h == 2'd2) ? {WRAP_THIRD[DATA_WIDTH-2:0], 1'b0} :
                           (third_h == 2'd1) ? WRAP_THIRD : '0;
  assign third_carry     = (third_carry_sum >= 3'd6) ? DATA_WIDTH'(2) :
                           (third_carry_sum >= 3'd3) ? DATA_WIDTH'(1) : '0;
  assign third_q         = {1'b0, third_lo_q} + third_hi + third_carry;

  assign init_x    = nonzero(third_q);
  assign numer     = {a, {(2 * FRAC_BITS){1'b0}}};
  assign quo_sat   = (div_quo[NUM_W-1:DATA_WIDTH] != '0) ? '1 : div_quo[DATA_WIDTH-1:0];
  assign sum3      = {1'b0, x, 1'b0} + {2'b00, quo_sat};
  assign nx        = third_q;
  assign step      = (nx >= x) ? (nx - x) : (x - nx);
  assign tol_ok    = step <= DATA_WIDTH'(cfg.tolerance);
  assign iters_inc = iters + ITER_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    a       <= a_next;
    x       <= x_next;
    iters   <= iters_next;
    conv    <= conv_next;
    third_l <= third_l_next;
    third_h <= third_h_next;
  end

  // The product is registered every cycle and read in the cycle after third_l
  // is loaded. Both operands are DATA_WIDTH bits wide.
  always_ff @(posedge clk) begin
    third_prod <= PROD_W'(third_l) * PROD_W'(RECIP3);
  end

  always_comb begin
    state_next       = state;
    a_next           = a;
    x_next           = x;
    iters_next       = iters;
    conv_next        = conv;
    third_l_next     = third_l;
    third_h_next     = third_h;
    in_ready         = 1'b0;
    res_valid        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = numer;
    div_req.divisor  = nonzero(x);
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          a_next = radicand;
          if (radicand == '0) begin
            x_next     = '0;
            iters_next = '0;
            conv_next  = 1'b1;
            state_next = S_FINISH;
          end else begin
            third_l_next = radicand;
            third_h_next = 2'b00;
            state_next   = S_SEED_MUL;
          end
        end
      end
      S_SEED_MUL: begin
        state_next = S_SEED;
      end
      S_SEED: begin
        x_next     = init_x;
        iters_next = '0;
        conv_next  = 1'b0;
        if (cfg.iteration_limit == '0) begin
          state_next = S_FINISH;
        end else begin
          div_req.start   = 1'b1;
          div_req.divisor = init_x;
          state_next      = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_done) begin
          div_req.start    = 1'b1;
          div_req.dividend = div_quo;
          state_next       = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_done) begin
          third_l_next = sum3[DATA_WIDTH-1:0];
          third_h_next = sum3[DATA_WIDTH+1:DATA_WIDTH];
          state_next   = S_STEP_MUL;
        end
      end
      S_STEP_MUL: begin
        state_next = S_STEP;
      end
      S_STEP: begin
        x_next     = nx;
        iters_next = iters_inc;
        if (tol_ok) begin
          conv_next  = 1'b1;
          state_next = S_FINISH;
        end else if (iters_inc == cfg.iteration_limit) begin
          state_next = S_FINISH;
        end else begin
          div_req.start   = 1'b1;
          div_req.divisor = nonzero(nx);
          state_next      = S_DIV1;
        end
      end
      S_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  assign res.root            = x;
  assign res.iterations_used = iters;
  assign res.converged       = conv;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while waiting");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV1 || state == S_DIV2))
    else $error("divider finished outside a wait state");

  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV1 |-> iters < cfg.iteration_limit)
    else $error("iteration started past the limit");

  a_limit_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.converged |-> res.iterations_used == cfg.iteration_limit)
    else $error("unconverged result below the iteration limit");

endmodule

@@ design/newton_cube_root_unit.sv @@
// ----------------------------------------------------------------------------
// newton_cube_root_unit: Newton-Raphson cube root of an unsigned fixed-point value
// Configuration registers, the output register, the iteration sequencer and
// the shared divider.
// ----------------------------------------------------------------------------
// The unit takes one unsigned Q16.16 radicand per input beat and returns one
// output beat holding the Q16.16 cube root, the number of Newton iterations
// performed and a converged flag. The estimate starts at radicand/3 (at least
// one LSB) and each step computes x' = (2x + a*2^32/x^2) / 3 with truncating
// integer arithmetic, the quotient saturating at all ones. Iteration stops
// once two successive estimates differ by no more than the tolerance register
// (converged set) or when the iteration limit register is reached (converged
// clear). A zero radicand returns zero with no iterations and converged set.
// The two divisions by the estimate in every Newton step go through a single
// restoring divider that produces one quotient bit per cycle. The divisions by
// three, for the seed and at the end of every step, use a registered
// reciprocal multiplication. The unit accepts one item at a time; a finished
// result sits in an output register, so the next input beat is taken while it
// waits. Registers sit on the APB port at byte address 0 (tolerance, 16 bits,
// reset 1) and 4 (iteration limit, 8 bits, reset 64) and should be written
// only while the unit is idle.
// ----------------------------------------------------------------------------
module newton_cube_root_unit
  import cbrt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_WIDTH-1:0] radicand,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] root,
  output logic [ITER_W-1:0]     iterations_used,
  output logic                  converged
);

  cfg_t       cfg;
  reg_index_t reg_sel;
  logic       cfg_write;

  logic       res_valid;
  logic       res_ready;
  res_t       res;
  res_t       out_res;

  div_req_t          div_req;
  logic              div_done;
  logic [NUM_W-1:0]  div_quo;

  // Registers are one word apart, so address bit 2 picks the register.
  assign reg_sel   = reg_index_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tolerance       <= TOL_RESET;
      cfg.iteration_limit <= ITER_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_TOLERANCE:  cfg.tolerance       <= pwdata[TOL_W-1:0];
        REG_ITER_LIMIT: cfg.iteration_limit <= pwdata[ITER_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TOLERANCE:  prdata = PDATA_W'(cfg.tolerance);
      REG_ITER_LIMIT: prdata = PDATA_W'(cfg.iteration_limit);
    endcase
  end

  // The output register takes a finished result whenever it is empty or its
  // current beat leaves in the same cycle, so the sequencer is freed at once.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign root            = out_res.root;
  assign iterations_used = out_res.iterations_used;
  assign converged       = out_res.converged;

  cbrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .radicand  (radicand),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .div_req   (div_req),
    .div_done  (div_done),
    .div_quo   (div_quo)
  );

  cbrt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

endmodule
